FILE: rtl/tsfc_pkg.sv
package tsfc_pkg;

	localparam int WORD_W   = 16;
	localparam int SAMPLE_W = 13;
	localparam int SUM_W    = 17;
	localparam int GAIN_W   = 24;
	localparam int OFS_W    = 16;
	localparam int SCR_W    = 12;
	localparam int STATUS_W = 2;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int SHIFT_IN = 3;

	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_VALID  = 2'd0;
	localparam status_t ST_JITTER = 2'd1;
	localparam status_t ST_WINDOW = 2'd2;

	typedef logic [1:0] burst_id_t;
	localparam burst_id_t BURST_X0 = 2'd0;
	localparam burst_id_t BURST_Y0 = 2'd1;
	localparam burst_id_t BURST_X1 = 2'd2;
	localparam burst_id_t BURST_Y1 = 2'd3;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_X_GAIN   = 3'd0;
	localparam reg_idx_t REG_Y_GAIN   = 3'd1;
	localparam reg_idx_t REG_X_OFFSET = 3'd2;
	localparam reg_idx_t REG_Y_OFFSET = 3'd3;
	localparam reg_idx_t REG_JITTER   = 3'd4;
	localparam reg_idx_t REG_X_WINDOW = 3'd5;
	localparam reg_idx_t REG_Y_WINDOW = 3'd6;

	typedef struct packed {
		burst_id_t          burst;
		logic [SUM_W-1:0]   trimmed;
	} burst_rec_t;

	typedef struct packed {
		status_t               status;
		logic [SAMPLE_W-1:0]   raw_x;
		logic [SAMPLE_W-1:0]   raw_y;
		logic [SCR_W-1:0]      screen_x;
		logic [SCR_W-1:0]      screen_y;
	} result_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] x_gain;
		logic signed [GAIN_W-1:0] y_gain;
		logic signed [OFS_W-1:0]  x_offset;
		logic signed [OFS_W-1:0]  y_offset;
		logic [SAMPLE_W-1:0]      jitter_limit;
		logic [SAMPLE_W-1:0]      x_win_lo;
		logic [SAMPLE_W-1:0]      x_win_hi;
		logic [SAMPLE_W-1:0]      y_win_lo;
		logic [SAMPLE_W-1:0]      y_win_hi;
	} cfg_t;

endpackage

FILE: rtl/tsfc_fifo.sv
module tsfc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/tsfc_regs.sv
module tsfc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tsfc_pkg::ADDR_W-1:0]  paddr,
	input  logic [tsfc_pkg::DATA_W-1:0]  pwdata,
	output logic [tsfc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output tsfc_pkg::cfg_t               cfg
);

	import tsfc_pkg::*;

	logic [GAIN_W-1:0]   x_gain_q;
	logic [GAIN_W-1:0]   y_gain_q;
	logic [OFS_W-1:0]    x_offset_q;
	logic [OFS_W-1:0]    y_offset_q;
	logic [SAMPLE_W-1:0] jitter_q;
	logic [2*SAMPLE_W-1:0] x_win_q;
	logic [2*SAMPLE_W-1:0] y_win_q;
	reg_idx_t            idx;
	logic                wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_gain_q   <= 24'h100000;
			y_gain_q   <= 24'h100000;
			x_offset_q <= '0;
			y_offset_q <= '0;
			jitter_q   <= 13'd64;
			x_win_q    <= {13'h1FFF, 13'h0000};
			y_win_q    <= {13'h1FFF, 13'h0000};
		end else if (wr_en) begin
			case (idx)
				REG_X_GAIN:   x_gain_q   <= pwdata[GAIN_W-1:0];
				REG_Y_GAIN:   y_gain_q   <= pwdata[GAIN_W-1:0];
				REG_X_OFFSET: x_offset_q <= pwdata[OFS_W-1:0];
				REG_Y_OFFSET: y_offset_q <= pwdata[OFS_W-1:0];
				REG_JITTER:   jitter_q   <= pwdata[SAMPLE_W-1:0];
				REG_X_WINDOW: x_win_q    <= pwdata[2*SAMPLE_W-1:0];
				REG_Y_WINDOW: y_win_q    <= pwdata[2*SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_X_GAIN:   prdata = {{(DATA_W-GAIN_W){1'b0}}, x_gain_q};
			REG_Y_GAIN:   prdata = {{(DATA_W-GAIN_W){1'b0}}, y_gain_q};
			REG_X_OFFSET: prdata = {{(DATA_W-OFS_W){1'b0}}, x_offset_q};
			REG_Y_OFFSET: prdata = {{(DATA_W-OFS_W){1'b0}}, y_offset_q};
			REG_JITTER:   prdata = {{(DATA_W-SAMPLE_W){1'b0}}, jitter_q};
			REG_X_WINDOW: prdata = {{(DATA_W-2*SAMPLE_W){1'b0}}, x_win_q};
			REG_Y_WINDOW: prdata = {{(DATA_W-2*SAMPLE_W){1'b0}}, y_win_q};
			default:      prdata = '0;
		endcase
	end

	always_comb begin
		cfg.x_gain       = x_gain_q;
		cfg.y_gain       = y_gain_q;
		cfg.x_offset     = x_offset_q;
		cfg.y_offset     = y_offset_q;
		cfg.jitter_limit = jitter_q;
		cfg.x_win_lo     = x_win_q[SAMPLE_W-1:0];
		cfg.x_win_hi     = x_win_q[2*SAMPLE_W-1:SAMPLE_W];
		cfg.y_win_lo     = y_win_q[SAMPLE_W-1:0];
		cfg.y_win_hi     = y_win_q[2*SAMPLE_W-1:SAMPLE_W];
	end

endmodule

FILE: rtl/tsfc_front.sv
module tsfc_front #(
	parameter int SAMPLES_PER_BURST = 8,
	parameter int MID_DEPTH         = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [tsfc_pkg::WORD_W-1:0]      sample_word,
	input  logic                             scan_start,
	input  logic [$clog2(MID_DEPTH+1)-1:0]   mid_count,
	output logic                             rec_push,
	output tsfc_pkg::burst_rec_t             rec
);

	import tsfc_pkg::*;

	localparam int POS_W = $clog2(SAMPLES_PER_BURST);
	localparam int FW    = $clog2(MID_DEPTH+1) + 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(SAMPLES_PER_BURST-1);

	logic [POS_W-1:0]    pos_q;
	logic [POS_W-1:0]    cur_pos;
	burst_id_t           burst_q;
	burst_id_t           cur_burst;
	logic [SAMPLE_W-1:0] smp;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [SUM_W-1:0]    nsum;
	logic [SAMPLE_W-1:0] nmax;
	logic [SAMPLE_W-1:0] nmin;
	logic                accept;
	logic                first;
	logic                last;
	logic                valid_s1;
	burst_id_t           burst_s1;
	logic [SUM_W-1:0]    sum_s1;
	logic [SAMPLE_W-1:0] max_s1;
	logic [SAMPLE_W-1:0] min_s1;
	logic [SAMPLE_W:0]   mm;

	assign accept    = push && !full;
	assign full      = ({1'b0, mid_count} + FW'(valid_s1)) >= FW'(MID_DEPTH);
	assign smp       = sample_word[WORD_W-1:SHIFT_IN];
	assign cur_pos   = scan_start ? '0 : pos_q;
	assign cur_burst = scan_start ? BURST_X0 : burst_q;
	assign first     = (cur_pos == '0);
	assign last      = (cur_pos == LAST_POS);
	assign nsum      = first ? SUM_W'(smp) : sum_q + SUM_W'(smp);
	assign nmax      = (first || smp > max_q) ? smp : max_q;
	assign nmin      = (first || smp < min_q) ? smp : min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			burst_q  <= BURST_X0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && last;
			if (accept) begin
				if (last) begin
					pos_q   <= '0;
					burst_q <= cur_burst + 1'b1;
				end else begin
					pos_q   <= cur_pos + 1'b1;
					burst_q <= cur_burst;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q <= nsum;
			max_q <= nmax;
			min_q <= nmin;
		end
		if (accept && last) begin
			sum_s1   <= nsum;
			max_s1   <= nmax;
			min_s1   <= nmin;
			burst_s1 <= cur_burst;
		end
	end

	// trim largest and smallest sample, floor at zero
	assign mm          = {1'b0, max_s1} + {1'b0, min_s1};
	assign rec_push    = valid_s1;
	assign rec.burst   = burst_s1;
	assign rec.trimmed = (sum_s1 >= SUM_W'(mm)) ? sum_s1 - SUM_W'(mm) : '0;

endmodule

FILE: rtl/tsfc_back.sv
module tsfc_back #(
	parameter int SAMPLES_PER_BURST  = 8,
	parameter int SCREEN_X_MAX       = 239,
	parameter int SCREEN_Y_MAX       = 319,
	parameter int GAIN_FRACTION_BITS = 20,
	parameter int OUT_DEPTH          = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rec_empty,
	input  tsfc_pkg::burst_rec_t             rec,
	output logic                             rec_pop,
	input  tsfc_pkg::cfg_t                   cfg,
	input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
	output logic                             res_push,
	output tsfc_pkg::result_t                res
);

	import tsfc_pkg::*;

	localparam int DIV   = SAMPLES_PER_BURST - 2;
	localparam int K     = SUM_W;
	localparam int RW    = K + 1;
	localparam int PRW   = K + RW;
	localparam int RECIP = (2**K) / DIV;
	localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
	localparam logic [RW-1:0] DIV_C   = RW'(DIV);
	localparam int MW    = SAMPLE_W + 1 + GAIN_W;
	localparam int TW    = (OFS_W + GAIN_FRACTION_BITS + 1 > MW + 1) ?
	                       OFS_W + GAIN_FRACTION_BITS + 1 : MW + 1;
	localparam int CW    = $clog2(OUT_DEPTH+1) + 1;
	localparam logic [SCR_W-1:0] SX_MAX = SCR_W'(SCREEN_X_MAX);
	localparam logic [SCR_W-1:0] SY_MAX = SCR_W'(SCREEN_Y_MAX);

	logic                v_s1, v_s2, v_s3, v_s4;
	logic [PRW-1:0]      prod_s1;
	logic [SUM_W-1:0]    trim_s1;
	burst_id_t           burst_s1;
	logic [RW-1:0]       q_est;
	logic [RW-1:0]       rem;
	logic [RW-1:0]       mean_full;
	logic [SAMPLE_W-1:0] mean_s2;
	burst_id_t           burst_s2;
	logic [SAMPLE_W-1:0] fx_q, fy_q, sx_q;
	logic [SAMPLE_W:0]   ax_sum, ay_sum;
	logic [SAMPLE_W-1:0] ax, ay, dx, dy;
	logic                jit, win_bad;
	status_t             status_s3, status_s4;
	logic [SAMPLE_W-1:0] ax_s3, ay_s3, ax_s4, ay_s4;
	logic signed [MW-1:0] px_s4, py_s4;
	logic signed [TW-1:0] tx, ty;
	logic                credit_ok;

	function automatic logic [SCR_W-1:0] calib(input logic signed [TW-1:0] t,
	                                           input logic [SCR_W-1:0] maxv);
		logic [TW-1:0] q;
		q = TW'(t >>> GAIN_FRACTION_BITS);
		if (t <= 0) begin
			calib = '0;
		end else if (q > TW'(maxv)) begin
			calib = maxv;
		end else begin
			calib = q[SCR_W-1:0];
		end
	endfunction

	// keep room in the result queue for everything in flight
	assign credit_ok = (CW'(out_count) + CW'(v_s1) + CW'(v_s2) + CW'(v_s3) + CW'(v_s4))
	                   < CW'(OUT_DEPTH);
	assign rec_pop   = !rec_empty && credit_ok;

	// divide by burst length less two: reciprocal, then one correction step
	assign q_est     = prod_s1[PRW-1:K];
	assign rem       = RW'(trim_s1) - q_est * DIV_C;
	assign mean_full = (rem >= DIV_C) ? q_est + 1'b1 : q_est;

	assign ax_sum  = {1'b0, fx_q} + {1'b0, sx_q};
	assign ay_sum  = {1'b0, fy_q} + {1'b0, mean_s2};
	assign ax      = ax_sum[SAMPLE_W:1];
	assign ay      = ay_sum[SAMPLE_W:1];
	assign dx      = (fx_q > sx_q) ? fx_q - sx_q : sx_q - fx_q;
	assign dy      = (fy_q > mean_s2) ? fy_q - mean_s2 : mean_s2 - fy_q;
	assign jit     = (dx > cfg.jitter_limit) || (dy > cfg.jitter_limit);
	assign win_bad = (ax < cfg.x_win_lo) || (ax > cfg.x_win_hi) ||
	                 (ay < cfg.y_win_lo) || (ay > cfg.y_win_hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= rec_pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && (burst_s2 == BURST_Y1);
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			prod_s1  <= PRW'(rec.trimmed) * PRW'(RECIP_C);
			trim_s1  <= rec.trimmed;
			burst_s1 <= rec.burst;
		end
		if (v_s1) begin
			mean_s2  <= mean_full[SAMPLE_W-1:0];
			burst_s2 <= burst_s1;
		end
		if (v_s2) begin
			unique case (burst_s2)
				BURST_X0: fx_q <= mean_s2;
				BURST_Y0: fy_q <= mean_s2;
				BURST_X1: sx_q <= mean_s2;
				BURST_Y1: begin
					ax_s3 <= ax;
					ay_s3 <= ay;
					priority if (jit) begin
						status_s3 <= ST_JITTER;
					end else if (win_bad) begin
						status_s3 <= ST_WINDOW;
					end else begin
						status_s3 <= ST_VALID;
					end
				end
			endcase
		end
		if (v_s3) begin
			px_s4     <= $signed({1'b0, ax_s3}) * cfg.x_gain;
			py_s4     <= $signed({1'b0, ay_s3}) * cfg.y_gain;
			ax_s4     <= ax_s3;
			ay_s4     <= ay_s3;
			status_s4 <= status_s3;
		end
	end

	assign tx = TW'(px_s4) + (TW'($signed(cfg.x_offset)) <<< GAIN_FRACTION_BITS);
	assign ty = TW'(py_s4) + (TW'($signed(cfg.y_offset)) <<< GAIN_FRACTION_BITS);

	assign res_push     = v_s4;
	assign res.status   = status_s4;
	assign res.raw_x    = ax_s4;
	assign res.raw_y    = ay_s4;
	assign res.screen_x = (status_s4 == ST_VALID) ? calib(tx, SX_MAX) : '0;
	assign res.screen_y = (status_s4 == ST_VALID) ? calib(ty, SY_MAX) : '0;

endmodule

FILE: rtl/touch_sample_filter_calibrate.sv
// a result passes the front register, middle queue and back stages s1-s4 to the result queue
// throughput: one sample per cycle; a sample is refused only when the burst queue
//   between the front and back ends has no room, which follows a stalled result side
// the burst divide, jitter/window checks and calibration multiply are pipelined in the back end
// reset: asynchronous, active low; clears the scan position, the queues and all
//   pipeline valids, and loads the calibration registers with their defaults
module touch_sample_filter_calibrate #(
	parameter int SAMPLES_PER_BURST  = 8,
	parameter int SCREEN_X_MAX       = 239,
	parameter int SCREEN_Y_MAX       = 319,
	parameter int GAIN_FRACTION_BITS = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// sample input, queue style
	input  logic                             push,
	output logic                             full,
	input  logic [tsfc_pkg::WORD_W-1:0]      sample_word,
	input  logic                             scan_start,
	// scan results, queue style
	output logic                             empty,
	input  logic                             pop,
	output logic [tsfc_pkg::STATUS_W-1:0]    status,
	output logic [tsfc_pkg::SAMPLE_W-1:0]    raw_x,
	output logic [tsfc_pkg::SAMPLE_W-1:0]    raw_y,
	output logic [tsfc_pkg::SCR_W-1:0]       screen_x,
	output logic [tsfc_pkg::SCR_W-1:0]       screen_y,
	// register port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [tsfc_pkg::ADDR_W-1:0]      paddr,
	input  logic [tsfc_pkg::DATA_W-1:0]      pwdata,
	output logic [tsfc_pkg::DATA_W-1:0]      prdata,
	output logic                             pready
);

	import tsfc_pkg::*;

	// one request per burst crosses the middle queue
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;
	localparam int MID_CW    = $clog2(MID_DEPTH+1);
	localparam int OUT_CW    = $clog2(OUT_DEPTH+1);

	cfg_t              cfg;
	burst_rec_t        rec_in;
	burst_rec_t        rec_out;
	logic              rec_push;
	logic              rec_pop;
	logic              mid_empty;
	logic              mid_full;
	logic [MID_CW-1:0] mid_count;
	result_t           res_in;
	result_t           res_out;
	logic              res_push;
	logic              out_full;
	logic [OUT_CW-1:0] out_count;

	// calibration and limit registers
	tsfc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// front end: sample position tracking and running sum / max / min per burst
	tsfc_front #(
		.SAMPLES_PER_BURST (SAMPLES_PER_BURST),
		.MID_DEPTH         (MID_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.sample_word (sample_word),
		.scan_start  (scan_start),
		.mid_count   (mid_count),
		.rec_push    (rec_push),
		.rec         (rec_in)
	);

	// finished bursts waiting for the back end
	tsfc_fifo #(
		.WIDTH ($bits(burst_rec_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec_in),
		.pop    (rec_pop),
		.rdata  (rec_out),
		.empty  (mid_empty),
		.full   (mid_full),
		.count  (mid_count)
	);

	// back end: mean, scan checks, calibration
	tsfc_back #(
		.SAMPLES_PER_BURST  (SAMPLES_PER_BURST),
		.SCREEN_X_MAX       (SCREEN_X_MAX),
		.SCREEN_Y_MAX       (SCREEN_Y_MAX),
		.GAIN_FRACTION_BITS (GAIN_FRACTION_BITS),
		.OUT_DEPTH          (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_empty (mid_empty),
		.rec       (rec_out),
		.rec_pop   (rec_pop),
		.cfg       (cfg),
		.out_count (out_count),
		.res_push  (res_push),
		.res       (res_in)
	);

	// result queue, its head drives the result ports
	tsfc_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty),
		.full   (out_full),
		.count  (out_count)
	);

	assign status   = res_out.status;
	assign raw_x    = res_out.raw_x;
	assign raw_y    = res_out.raw_y;
	assign screen_x = res_out.screen_x;
	assign screen_y = res_out.screen_y;

`ifndef SYNTHESIS
	// a finished burst must always find room in the middle queue
	a_mid_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(rec_push && mid_full))
		else $error("burst request dropped at full middle queue");

	// back end credit keeps the result queue from overflowing
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_push && out_full))
		else $error("scan result dropped at full result queue");

	// no sample taken while the middle queue has no room
	a_full_when_mid_full: assert property (@(posedge clk) disable iff (!arst_n)
		(mid_count == MID_CW'(MID_DEPTH)) |-> full)
		else $error("input open with middle queue full");
`endif

endmodule
